>>> design/smu_pkg.sv
// shared constants, word types and the unit sign rule of the sedenion multiplier
package smu_pkg;

   localparam int COMPONENTS            = 16;
   localparam int IDX_BITS              = 4;
   localparam int DATA_BITS             = 32;
   localparam int PROD_BITS             = 2 * DATA_BITS;
   // sixteen products of up to 2^62 in magnitude, plus sign
   localparam int ACC_BITS              = PROD_BITS + 4;
   localparam int FRACTION_BITS_DEFAULT = 16;

   typedef struct packed {
      logic [IDX_BITS-1:0]         component_index;
      logic signed [DATA_BITS-1:0] left_component;
      logic signed [DATA_BITS-1:0] right_component;
      logic                        load_last;
   } smu_req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]         product_index;
      logic signed [DATA_BITS-1:0] product_component;
      logic                        saturated;
      logic                        product_last;
   } smu_rsp_type;

   // 1 when e_p * e_q carries a minus sign under the doubling rule
   function automatic logic unit_neg(input logic [IDX_BITS-1:0] p,
                                     input logic [IDX_BITS-1:0] q);
      logic                s;
      logic [IDX_BITS-1:0] pp;
      logic [IDX_BITS-1:0] qq;
      logic [IDX_BITS-1:0] pl;
      logic [IDX_BITS-1:0] ql;
      logic [IDX_BITS-1:0] h;
      logic                ph;
      logic                qh;
      s  = 1'b0;
      pp = p;
      qq = q;
      for (int n = IDX_BITS - 1; n >= 0; n--) begin
         h  = IDX_BITS'(1 << n);
         ph = |(pp & h);
         qh = |(qq & h);
         pl = pp & (h - IDX_BITS'(1));
         ql = qq & (h - IDX_BITS'(1));
         case ({ph, qh})
            2'b00: begin
               pp = pl;
               qq = ql;
            end
            2'b01: begin
               pp = ql;
               qq = pl;
            end
            2'b10: begin
               s  = s ^ (ql != '0);
               pp = pl;
               qq = ql;
            end
            default: begin
               s  = s ^ 1'b1 ^ (ql != '0);
               pp = ql;
               qq = pl;
            end
         endcase
      end
      return s;
   endfunction

endpackage

>>> design/smu_ram.sv
// generic single-write, single-read ram with registered read data
module smu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sedenion_multiplier_unit.sv
// sedenion multiplier top level: operand rams, term pipeline, rounding and result queue
//
//  channel | direction | handshake         | word
//  req     | in        | req_valid/stall   | smu_req_type, one component pair
//  rsp     | out       | rsp_valid/stall   | smu_rsp_type, one product component
//
// a load word is taken while req_stall is low; a word with load_last starts the product
// one shared 32x32 multiplier works through 16 terms per component, and req_stall is high
// until the last term is issued; results leave through a two-word queue; a stalled rsp side
// holds the issue loop at the next component boundary
// reset clears the slot valid bits, so unloaded slots read as zero; no ram sweep
module sedenion_multiplier_unit #(
   parameter int FRACTION_BITS = smu_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  smu_pkg::smu_req_type req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output smu_pkg::smu_rsp_type rsp_word
);

   localparam int IDX_BITS  = smu_pkg::IDX_BITS;
   localparam int DATA_BITS = smu_pkg::DATA_BITS;
   localparam int PROD_BITS = smu_pkg::PROD_BITS;
   localparam int ACC_BITS  = smu_pkg::ACC_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(smu_pkg::COMPONENTS - 1);
   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< (FRACTION_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] MAX_VAL =
      {{(ACC_BITS-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] MIN_VAL =
      {{(ACC_BITS-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}};

   typedef enum logic {
      ST_LOAD,
      ST_RUN
   } state_type;

   // control
   state_type                 state_ff, state_in;
   logic [IDX_BITS-1:0]       i_ff, i_in;
   logic [IDX_BITS-1:0]       k_ff, k_in;
   logic [1:0]                occ_ff, occ_in;
   logic [smu_pkg::COMPONENTS-1:0] valid_ff, valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      hold_valid_ff, hold_valid_in;
   smu_pkg::smu_rsp_type      out_ff, out_in;
   smu_pkg::smu_rsp_type      hold_ff, hold_in;

   logic                      load;
   logic                      issue;
   logic                      start;
   logic                      take;
   logic [IDX_BITS-1:0]       j_addr;

   // term pipeline
   logic                      s1_valid_ff, s1_first_ff, s1_last_ff, s1_neg_ff;
   logic                      s1_lv_ff, s1_rv_ff;
   logic [IDX_BITS-1:0]       s1_k_ff;
   logic                      s2_valid_ff, s2_first_ff, s2_last_ff, s2_neg_ff;
   logic [IDX_BITS-1:0]       s2_k_ff;
   logic signed [PROD_BITS-1:0] s2_prod_ff;
   logic                      s3_done_ff;
   logic [IDX_BITS-1:0]       s3_k_ff;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;

   logic [DATA_BITS-1:0]      left_rd, right_rd;
   logic signed [DATA_BITS-1:0] a_op, b_op;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [ACC_BITS-1:0] prod_ext, term;
   logic signed [ACC_BITS-1:0] biased, rounded;
   logic                      sat_hi, sat_lo;
   smu_pkg::smu_rsp_type      fin_word;

   assign load      = (state_ff == ST_LOAD) && req_valid;
   assign req_stall = (state_ff != ST_LOAD);
   // a new component needs a free queue slot before its first term goes out
   assign issue     = (state_ff == ST_RUN) && ((i_ff != '0) || (occ_ff < 2'd2));
   assign start     = issue && (i_ff == '0);
   assign take      = out_valid_ff && !rsp_stall;
   assign j_addr    = i_ff ^ k_ff;

   smu_ram #(
      .WIDTH(DATA_BITS),
      .DEPTH(smu_pkg::COMPONENTS)
   ) u_left_ram (
      .clock  (clock),
      .wr_en  (load),
      .wr_addr(req_word.component_index),
      .wr_data(req_word.left_component),
      .rd_en  (issue),
      .rd_addr(i_ff),
      .rd_data(left_rd)
   );

   smu_ram #(
      .WIDTH(DATA_BITS),
      .DEPTH(smu_pkg::COMPONENTS)
   ) u_right_ram (
      .clock  (clock),
      .wr_en  (load),
      .wr_addr(req_word.component_index),
      .wr_data(req_word.right_component),
      .rd_en  (issue),
      .rd_addr(j_addr),
      .rd_data(right_rd)
   );

   // multiply stage; never-loaded slots count as zero
   assign a_op = s1_lv_ff ? $signed(left_rd) : '0;
   assign b_op = s1_rv_ff ? $signed(right_rd) : '0;
   assign prod = PROD_BITS'(a_op) * PROD_BITS'(b_op);

   // accumulate stage
   assign prod_ext = ACC_BITS'(s2_prod_ff);
   assign term     = s2_neg_ff ? -prod_ext : prod_ext;
   assign acc_in   = (s2_first_ff ? '0 : acc_ff) + term;

   // round half up, then clamp to the 32-bit range
   assign biased  = acc_ff + HALF;
   assign rounded = biased >>> FRACTION_BITS;
   assign sat_hi  = rounded > MAX_VAL;
   assign sat_lo  = rounded < MIN_VAL;

   always_comb begin
      fin_word.product_index = s3_k_ff;
      if (sat_hi) begin
         fin_word.product_component = MAX_VAL[DATA_BITS-1:0];
      end else if (sat_lo) begin
         fin_word.product_component = MIN_VAL[DATA_BITS-1:0];
      end else begin
         fin_word.product_component = rounded[DATA_BITS-1:0];
      end
      fin_word.saturated    = sat_hi || sat_lo;
      fin_word.product_last = (s3_k_ff == LAST_IDX);
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      valid_in      = valid_ff;
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      hold_in       = hold_ff;
      occ_in        = occ_ff + (start ? 2'd1 : 2'd0) - (take ? 2'd1 : 2'd0);

      unique case (state_ff)
         ST_LOAD: begin
            if (load) begin
               valid_in[req_word.component_index] = 1'b1;
               if (req_word.load_last) begin
                  state_in = ST_RUN;
                  i_in     = '0;
                  k_in     = '0;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               i_in = i_ff + IDX_BITS'(1);
               if (i_ff == LAST_IDX) begin
                  k_in = k_ff + IDX_BITS'(1);
                  if (k_ff == LAST_IDX) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // two-word result queue: out_ff drives the port, hold_ff waits behind it
      if (!out_valid_ff || take) begin
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_valid_in = 1'b1;
            if (s3_done_ff) begin
               hold_in = fin_word;
            end else begin
               hold_valid_in = 1'b0;
            end
         end else if (s3_done_ff) begin
            out_in       = fin_word;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (s3_done_ff) begin
         hold_in       = fin_word;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         i_ff          <= '0;
         k_ff          <= '0;
         occ_ff        <= '0;
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         k_ff          <= k_in;
         occ_ff        <= occ_in;
         valid_ff      <= valid_in;
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_done_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_done_ff  <= s2_valid_ff && s2_last_ff;
      end
      s1_first_ff <= (i_ff == '0);
      s1_last_ff  <= (i_ff == LAST_IDX);
      s1_neg_ff   <= smu_pkg::unit_neg(i_ff, j_addr);
      s1_lv_ff    <= valid_ff[i_ff];
      s1_rv_ff    <= valid_ff[j_addr];
      s1_k_ff     <= k_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_neg_ff   <= s1_neg_ff;
      s2_k_ff     <= s1_k_ff;
      s2_prod_ff  <= prod;
      s3_k_ff     <= s2_k_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule
